// ===== sv/ssoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Scan sector obstacle classifier - shared definitions
// Register map, level codes and the control group between the top level and
// the window accumulators.
// ----------------------------------------------------------------------------
package ssoc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WIN_IDX_W  = 10;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned LEVEL_W    = 2;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [WIN_IDX_W-1:0]  win_idx_t;
  typedef logic [THR_W-1:0]      thr_t;
  typedef logic [LEVEL_W-1:0]    level_t;

  localparam cfg_idx_t REG_LEFT_FIRST  = 3'd0;
  localparam cfg_idx_t REG_LEFT_LAST   = 3'd1;
  localparam cfg_idx_t REG_RIGHT_FIRST = 3'd2;
  localparam cfg_idx_t REG_RIGHT_LAST  = 3'd3;
  localparam cfg_idx_t REG_RANGE_LOW   = 3'd4;
  localparam cfg_idx_t REG_RANGE_HIGH  = 3'd5;
  localparam cfg_idx_t REG_WARN_THR    = 3'd6;
  localparam cfg_idx_t REG_DANGER_THR  = 3'd7;

  localparam level_t LVL_SAFE    = 2'd0;
  localparam level_t LVL_WARNING = 2'd1;
  localparam level_t LVL_DANGER  = 2'd2;

  localparam cfg_data_t RANGE_LOW_RST  = 16'd0;
  localparam cfg_data_t RANGE_HIGH_RST = 16'hFFFF;
  localparam thr_t      WARN_THR_RST   = 16'd737;
  localparam thr_t      DANGER_THR_RST = 16'd655;

  typedef struct packed {
    logic advance;
    logic hit;
    logic scan_end;
  } acc_ctrl_t;

endpackage

// ===== sv/ssoc_window_acc.sv =====
// ----------------------------------------------------------------------------
// Window accumulator
// Saturating sum and count of the valid samples of one window, cleared after
// the last sample of each scan. Presents the totals including the current
// sample.
// ----------------------------------------------------------------------------
module ssoc_window_acc
  import ssoc_pkg::*;
#(
  parameter int unsigned RANGE_W = 16,
  parameter int unsigned SUM_W   = 26,
  parameter int unsigned CNT_W   = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acc_ctrl_t          ctrl_i,
  input  logic [RANGE_W-1:0] range_i,
  output logic [SUM_W-1:0]   sum_o,
  output logic [CNT_W-1:0]   count_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] count_new;

  assign sum_add   = {1'b0, sum_q} + {{(SUM_W + 1 - RANGE_W){1'b0}}, range_i};
  assign sum_new   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign count_new = (&count_q) ? count_q : count_q + {{(CNT_W-1){1'b0}}, 1'b1};

  assign sum_o   = ctrl_i.hit ? sum_new : sum_q;
  assign count_o = ctrl_i.hit ? count_new : count_q;

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.scan_end) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_o;
        count_d = count_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/ssoc_classify.sv =====
// ----------------------------------------------------------------------------
// Window classifier
// Grades one window's average against the danger and warning thresholds by
// comparing the sum with threshold times count.
// ----------------------------------------------------------------------------
module ssoc_classify
  import ssoc_pkg::*;
#(
  parameter int unsigned SUM_W = 26,
  parameter int unsigned CNT_W = 11
) (
  input  logic [SUM_W-1:0] sum_i,
  input  logic [CNT_W-1:0] count_i,
  input  thr_t             warn_thr_i,
  input  thr_t             danger_thr_i,
  output level_t           level_o
);

  localparam int unsigned PROD_W = THR_W + CNT_W;
  localparam int unsigned CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  logic [PROD_W-1:0] warn_prod, danger_prod;
  logic [CMP_W-1:0]  sum_ext, warn_ext, danger_ext;

  assign warn_prod   = {{CNT_W{1'b0}}, warn_thr_i} * {{THR_W{1'b0}}, count_i};
  assign danger_prod = {{CNT_W{1'b0}}, danger_thr_i} * {{THR_W{1'b0}}, count_i};

  assign sum_ext    = {{(CMP_W - SUM_W){1'b0}}, sum_i};
  assign warn_ext   = {{(CMP_W - PROD_W){1'b0}}, warn_prod};
  assign danger_ext = {{(CMP_W - PROD_W){1'b0}}, danger_prod};

  always_comb begin
    if (sum_ext < danger_ext) begin
      level_o = LVL_DANGER;
    end else if (sum_ext < warn_ext) begin
      level_o = LVL_WARNING;
    end else begin
      level_o = LVL_SAFE;
    end
  end

endmodule

// ===== sv/scan_sector_obstacle_classifier.sv =====
// Path: a scan end passes the input, snapshot and result registers in turn.
// Throughput: one sample per cycle; the input register, the snapshot register
// and the result register each hold one item, so a stalled result only blocks
// input once a further scan end reaches the full snapshot stage.
// Reset: configuration returns to its default values, sums, counts and the
// held level clear to zero (safe), and all pipeline stages empty.
// ----------------------------------------------------------------------------
// Scan sector obstacle classifier - top level
// Accumulates two index windows of a range scan and grades them into one
// obstacle level per scan.
// ----------------------------------------------------------------------------
module scan_sector_obstacle_classifier
  import ssoc_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned RANGE_BITS  = 16,
  localparam int unsigned IDX_W      = $clog2(MAX_SAMPLES),
  localparam int unsigned CNT_W      = IDX_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IDX_W-1:0]      sample_index_i,
  input  logic [RANGE_BITS-1:0] range_sample_i,
  input  logic                  scan_end_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output level_t                obstacle_level_o,
  output logic [CNT_W-1:0]      left_valid_count_o,
  output logic [CNT_W-1:0]      right_valid_count_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cfg_idx_t              cfg_index_i,
  input  cfg_data_t             cfg_data_i
);

  localparam int unsigned SUM_W  = RANGE_BITS + IDX_W;
  localparam int unsigned IDXC_W = (IDX_W > WIN_IDX_W) ? IDX_W : WIN_IDX_W;
  localparam int unsigned RNGC_W = (RANGE_BITS > CFG_DATA_W) ? RANGE_BITS : CFG_DATA_W;

  // configuration
  win_idx_t  left_first_q, left_last_q, right_first_q, right_last_q;
  cfg_data_t range_low_q, range_high_q;
  thr_t      warn_thr_q, danger_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_first_q  <= '0;
      left_last_q   <= '0;
      right_first_q <= '0;
      right_last_q  <= '0;
      range_low_q   <= RANGE_LOW_RST;
      range_high_q  <= RANGE_HIGH_RST;
      warn_thr_q    <= WARN_THR_RST;
      danger_thr_q  <= DANGER_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_LEFT_FIRST:  left_first_q  <= cfg_data_i[WIN_IDX_W-1:0];
        REG_LEFT_LAST:   left_last_q   <= cfg_data_i[WIN_IDX_W-1:0];
        REG_RIGHT_FIRST: right_first_q <= cfg_data_i[WIN_IDX_W-1:0];
        REG_RIGHT_LAST:  right_last_q  <= cfg_data_i[WIN_IDX_W-1:0];
        REG_RANGE_LOW:   range_low_q   <= cfg_data_i;
        REG_RANGE_HIGH:  range_high_q  <= cfg_data_i;
        REG_WARN_THR:    warn_thr_q    <= cfg_data_i;
        REG_DANGER_THR:  danger_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_valid_q, in_last_q;
  logic snap_valid_q, out_valid_q;
  logic out_ready, snap_ready, in_ready, s1_adv, snap_load, out_load;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign snap_ready = !snap_valid_q || out_ready;
  assign s1_adv     = in_valid_q && (!in_last_q || snap_ready);
  assign in_ready   = !in_valid_q || s1_adv;
  assign snap_load  = s1_adv && in_last_q;
  assign out_load   = snap_valid_q && out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (snap_ready) begin
        snap_valid_q <= snap_load;
      end
      if (out_ready) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  // input register
  logic [IDX_W-1:0]      in_idx_q;
  logic [RANGE_BITS-1:0] in_range_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_idx_q   <= sample_index_i;
      in_range_q <= range_sample_i;
      in_last_q  <= scan_end_i;
    end
  end

  // window match
  logic [IDXC_W-1:0] idx_ext;
  logic [RNGC_W-1:0] rng_ext;
  logic              range_ok, left_hit, right_hit;

  assign idx_ext  = {{(IDXC_W - IDX_W){1'b0}}, in_idx_q};
  assign rng_ext  = {{(RNGC_W - RANGE_BITS){1'b0}}, in_range_q};
  assign range_ok = (rng_ext >= {{(RNGC_W - CFG_DATA_W){1'b0}}, range_low_q})
                 && (rng_ext <= {{(RNGC_W - CFG_DATA_W){1'b0}}, range_high_q});
  assign left_hit = range_ok
                 && (idx_ext >= {{(IDXC_W - WIN_IDX_W){1'b0}}, left_first_q})
                 && (idx_ext <= {{(IDXC_W - WIN_IDX_W){1'b0}}, left_last_q});
  assign right_hit = range_ok
                  && (idx_ext >= {{(IDXC_W - WIN_IDX_W){1'b0}}, right_first_q})
                  && (idx_ext <= {{(IDXC_W - WIN_IDX_W){1'b0}}, right_last_q});

  acc_ctrl_t left_ctrl, right_ctrl;

  assign left_ctrl  = '{advance: s1_adv, hit: left_hit, scan_end: in_last_q};
  assign right_ctrl = '{advance: s1_adv, hit: right_hit, scan_end: in_last_q};

  logic [SUM_W-1:0] left_sum, right_sum;
  logic [CNT_W-1:0] left_cnt, right_cnt;

  ssoc_window_acc #(
    .RANGE_W (RANGE_BITS),
    .SUM_W   (SUM_W),
    .CNT_W   (CNT_W)
  ) u_left_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (left_ctrl),
    .range_i (in_range_q),
    .sum_o   (left_sum),
    .count_o (left_cnt)
  );

  ssoc_window_acc #(
    .RANGE_W (RANGE_BITS),
    .SUM_W   (SUM_W),
    .CNT_W   (CNT_W)
  ) u_right_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (right_ctrl),
    .range_i (in_range_q),
    .sum_o   (right_sum),
    .count_o (right_cnt)
  );

  // scan snapshot
  logic [SUM_W-1:0] snap_lsum_q, snap_rsum_q;
  logic [CNT_W-1:0] snap_lcnt_q, snap_rcnt_q;

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_lsum_q <= left_sum;
      snap_rsum_q <= right_sum;
      snap_lcnt_q <= left_cnt;
      snap_rcnt_q <= right_cnt;
    end
  end

  // grading
  level_t left_lvl, right_lvl, lvl_left_upd, lvl_next, level_q;

  ssoc_classify #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_left_cls (
    .sum_i        (snap_lsum_q),
    .count_i      (snap_lcnt_q),
    .warn_thr_i   (warn_thr_q),
    .danger_thr_i (danger_thr_q),
    .level_o      (left_lvl)
  );

  ssoc_classify #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_right_cls (
    .sum_i        (snap_rsum_q),
    .count_i      (snap_rcnt_q),
    .warn_thr_i   (warn_thr_q),
    .danger_thr_i (danger_thr_q),
    .level_o      (right_lvl)
  );

  assign lvl_left_upd = (snap_lcnt_q != '0) ? left_lvl : level_q;
  assign lvl_next     = ((snap_rcnt_q != '0) && (right_lvl > lvl_left_upd)) ?
                        right_lvl : lvl_left_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_SAFE;
    end else if (out_load) begin
      level_q <= lvl_next;
    end
  end

  // result register
  level_t           out_level_q;
  logic [CNT_W-1:0] out_lcnt_q, out_rcnt_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q <= lvl_next;
      out_lcnt_q  <= snap_lcnt_q;
      out_rcnt_q  <= snap_rcnt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign obstacle_level_o    = out_level_q;
  assign left_valid_count_o  = out_lcnt_q;
  assign right_valid_count_o = out_rcnt_q;

`ifndef SYNTHESIS
  a_snap_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("snapshot left without a result");

  a_mid_scan_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_last_q) |-> !in_stall_o)
    else $error("input stalled on a sample that ends no scan");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid_q && !out_ready) |=> (snap_valid_q && $stable(snap_lsum_q)
                                      && $stable(snap_rcnt_q)))
    else $error("snapshot changed while result blocked");

  a_level_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_level_q == LVL_SAFE || out_level_q == LVL_WARNING
                     || out_level_q == LVL_DANGER))
    else $error("result carries an unused level code");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Scan sector obstacle classifier - testbench
// Streams range scans through the classifier with random idling on both
// sides. It grades each scan with its own sector model and compares every
// result field with it. Covered: register defaults, window and range edges,
// empty sectors and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import ssoc_pkg::*;

  localparam int unsigned IDX_W       = WIN_IDX_W;
  localparam int unsigned RANGE_W     = THR_W;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned SUM_W       = RANGE_W + IDX_W;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam sum_t   SUM_SAT = '1;
  localparam count_t CNT_SAT = '1;

  typedef struct packed {
    level_t level;
    count_t left_cnt;
    count_t right_cnt;
  } verdict_t;

  logic      clk_i;
  logic      rst_ni         = 1'b0;
  logic      in_valid_i     = 1'b0;
  logic      in_stall_o;
  index_t    sample_index_i = '0;
  range_t    range_sample_i = '0;
  logic      scan_end_i     = 1'b0;
  logic      out_valid_o;
  logic      out_stall_i    = 1'b0;
  level_t    obstacle_level_o;
  count_t    left_valid_count_o;
  count_t    right_valid_count_o;
  logic      cfg_valid_i    = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i    = REG_LEFT_FIRST;
  cfg_data_t cfg_data_i     = '0;

  // sector model: register copies and accumulators
  index_t left_lo_idx  = '0;
  index_t left_hi_idx  = '0;
  index_t right_lo_idx = '0;
  index_t right_hi_idx = '0;
  range_t range_floor  = RANGE_LOW_RST;
  range_t range_ceil   = RANGE_HIGH_RST;
  thr_t   warn_thr     = WARN_THR_RST;
  thr_t   danger_thr   = DANGER_THR_RST;
  sum_t   left_sum     = '0;
  sum_t   right_sum    = '0;
  count_t left_cnt     = '0;
  count_t right_cnt    = '0;
  level_t held_level   = LVL_SAFE;

  verdict_t    verdicts_due[$];
  int unsigned error_count      = 0;
  int unsigned samples_moved    = 0;
  int unsigned verdicts_checked = 0;
  int unsigned settings_used    = 0;
  bit          quiet            = 1'b0;
  bit          sender_gaps      = 1'b1;
  int unsigned holdoff_len      = 0;

  scan_sector_obstacle_classifier u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void store_reg(cfg_idx_t idx, cfg_data_t d);
    case (idx)
      REG_LEFT_FIRST:  left_lo_idx  = d[IDX_W-1:0];
      REG_LEFT_LAST:   left_hi_idx  = d[IDX_W-1:0];
      REG_RIGHT_FIRST: right_lo_idx = d[IDX_W-1:0];
      REG_RIGHT_LAST:  right_hi_idx = d[IDX_W-1:0];
      REG_RANGE_LOW:   range_floor  = d;
      REG_RANGE_HIGH:  range_ceil   = d;
      REG_WARN_THR:    warn_thr     = d;
      REG_DANGER_THR:  danger_thr   = d;
    endcase
  endfunction

  function automatic void add_range(inout sum_t s, inout count_t c, input range_t r);
    logic [SUM_W:0] total;
    total = s + r;
    s = (total > SUM_SAT) ? SUM_SAT : total[SUM_W-1:0];
    if (c != CNT_SAT) c = c + 1'b1;
  endfunction

  function automatic level_t grade_sector(sum_t s, count_t c);
    logic [THR_W+CNT_W-1:0] danger_bar;
    logic [THR_W+CNT_W-1:0] warn_bar;
    danger_bar = danger_thr * c;
    warn_bar   = warn_thr * c;
    if (s < danger_bar) return LVL_DANGER;
    if (s < warn_bar) return LVL_WARNING;
    return LVL_SAFE;
  endfunction

  function automatic void fold_sample(index_t idx, range_t r, logic last);
    logic     in_band;
    level_t   right_level;
    verdict_t due;
    in_band = (r >= range_floor) && (r <= range_ceil);
    if (in_band && idx >= left_lo_idx && idx <= left_hi_idx) add_range(left_sum, left_cnt, r);
    if (in_band && idx >= right_lo_idx && idx <= right_hi_idx) add_range(right_sum, right_cnt, r);
    if (last) begin
      if (left_cnt != 0) held_level = grade_sector(left_sum, left_cnt);
      if (right_cnt != 0) begin
        right_level = grade_sector(right_sum, right_cnt);
        if (right_level > held_level) held_level = right_level;
      end
      due = '{held_level, left_cnt, right_cnt};
      verdicts_due = {verdicts_due, due};
      left_sum  = '0;
      right_sum = '0;
      left_cnt  = '0;
      right_cnt = '0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb_top mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result with none due, level %0d", obstacle_level_o));
        end else begin
          want = verdicts_due.pop_front();
          verdicts_checked++;
          if (obstacle_level_o !== want.level)
            report_mismatch($sformatf("level %0d, want %0d", obstacle_level_o, want.level));
          if (left_valid_count_o !== want.left_cnt)
            report_mismatch($sformatf("left count %0d, want %0d",
                                      left_valid_count_o, want.left_cnt));
          if (right_valid_count_o !== want.right_cnt)
            report_mismatch($sformatf("right count %0d, want %0d",
                                      right_valid_count_o, want.right_cnt));
        end
      end
      if (cfg_valid_i && cfg_ready_o) store_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        fold_sample(sample_index_i, range_sample_i, scan_end_i);
        samples_moved++;
      end
    end
  end

  initial begin
    int unsigned n;
    @(posedge clk_i);
    forever begin
      if (holdoff_len != 0) begin
        n = holdoff_len;
        holdoff_len = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top timeout after %0d cycles, %0d results outstanding",
             cycle_count, verdicts_due.size());
    $display("tb_top: errors");
    $finish;
  end

  task automatic send_sample(index_t idx, range_t r, logic last);
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    range_sample_i <= r;
    scan_end_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!quiet && sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_regs(cfg_data_t lf, cfg_data_t ll, cfg_data_t rf, cfg_data_t rl,
                              cfg_data_t lo, cfg_data_t hi, cfg_data_t warn, cfg_data_t dang);
    drain_results();
    write_reg(REG_LEFT_FIRST, lf);
    write_reg(REG_LEFT_LAST, ll);
    write_reg(REG_RIGHT_FIRST, rf);
    write_reg(REG_RIGHT_LAST, rl);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_WARN_THR, warn);
    write_reg(REG_DANGER_THR, dang);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // index registers ignore the upper bits: fill them with noise
  function automatic cfg_data_t idx_word(int unsigned v);
    cfg_data_t w;
    w = cfg_data_t'($urandom);
    w[IDX_W-1:0] = index_t'(v);
    return w;
  endfunction

  task automatic send_scan(int unsigned len, index_t start, int centre, int spread,
                           int unsigned noise_pct);
    int     val;
    index_t idx;
    range_t r;
    for (int unsigned k = 0; k < len; k++) begin
      idx = start + index_t'(k);
      val = centre - spread + int'($urandom_range(0, 2 * spread));
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      r = range_t'(val);
      if ($urandom_range(0, 99) < noise_pct) begin
        idx = index_t'($urandom);
        r   = range_t'($urandom);
      end
      send_sample(idx, r, k == len - 1);
    end
  endtask

  task automatic random_scan(output int unsigned len);
    int unsigned pick;
    int unsigned noise;
    index_t      start;
    int          centre;
    int          spread;
    pick = $urandom_range(0, 9);
    len  = (pick == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    case ($urandom_range(0, 3))
      0:       start = left_lo_idx - index_t'($urandom_range(0, 4));
      1:       start = right_lo_idx - index_t'($urandom_range(0, 4));
      2:       start = left_hi_idx - index_t'($urandom_range(0, 12));
      default: start = index_t'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       centre = int'(danger_thr);
      1:       centre = int'(warn_thr);
      2:       centre = int'(range_floor);
      3:       centre = int'(range_ceil);
      4:       centre = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      default: centre = int'($urandom_range(0, 65535));
    endcase
    spread = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 3000));
    noise  = (pick == 1) ? 100 : $urandom_range(0, 8);
    send_scan(len, start, centre, spread, noise);
  endtask

  task automatic pick_settings(int unsigned phase);
    int unsigned lf, ll, rf, rl, lo, hi, warn, dang;
    lf   = $urandom_range(0, 1000);
    ll   = lf + $urandom_range(0, 60);
    rf   = ($urandom_range(0, 2) == 0) ? lf + $urandom_range(0, 30) : $urandom_range(0, 1000);
    rl   = rf + $urandom_range(0, 60);
    if (ll > 1023) ll = 1023;
    if (rf > 1023) rf = 1023;
    if (rl > 1023) rl = 1023;
    lo   = $urandom_range(0, 3000);
    hi   = $urandom_range(20000, 65535);
    dang = $urandom_range(0, 30000);
    warn = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : dang + $urandom_range(0, 30000);
    case (phase)
      0: begin
        lf = 0; ll = 1023; rf = 0; rl = 1023;
        lo = 0; hi = 65535; warn = 65535; dang = 65535;
      end
      1: begin
        lf = 1023; ll = 1023; rf = 0; rl = 0;
        lo = 65535; hi = 65535; warn = 0; dang = 0;
      end
      2: begin
        lf = $urandom_range(100, 1023);
        ll = lf - $urandom_range(1, 100);
      end
      3: begin
        lo = $urandom_range(30000, 65535);
        hi = $urandom_range(0, 29999);
      end
      default: ;
    endcase
    program_regs(idx_word(lf), idx_word(ll), idx_word(rf), idx_word(rl),
                 cfg_data_t'(lo), cfg_data_t'(hi), cfg_data_t'(warn), cfg_data_t'(dang));
  endtask

  task automatic run_random_items(int unsigned items);
    int unsigned n;
    while (items > 0) begin
      random_scan(n);
      items = (n >= items) ? 0 : items - n;
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(index_t'(0), range_t'(0), 1'b1);
    send_sample(index_t'(1023), range_t'(65535), 1'b1);
    send_sample(index_t'(0), range_t'(65535), 1'b0);
    send_sample(index_t'(0), range_t'(65535), 1'b1);
  endtask

  task automatic test_directed_cases();
    program_regs(idx_word(10), idx_word(20), idx_word(15), idx_word(25),
                 16'd100, 16'd60000, 16'd2000, 16'd1000);
    send_sample(index_t'(10), range_t'(3000), 1'b0);
    send_sample(index_t'(16), range_t'(1500), 1'b0);
    send_sample(index_t'(30), range_t'(50), 1'b0);
    send_sample(index_t'(12), range_t'(99), 1'b0);
    send_sample(index_t'(13), range_t'(60001), 1'b0);
    send_sample(index_t'(20), range_t'(100), 1'b1);
    send_sample(index_t'(11), range_t'(60000), 1'b1);
    send_sample(index_t'(25), range_t'(500), 1'b1);
    send_sample(index_t'(22), range_t'(5000), 1'b1);
    send_sample(index_t'(0), range_t'(65535), 1'b1);
    // inverted left window and inverted valid range
    program_regs(idx_word(20), idx_word(10), idx_word(15), idx_word(25),
                 16'd60000, 16'd100, 16'd2000, 16'd1000);
    send_sample(index_t'(15), range_t'(5000), 1'b0);
    send_sample(index_t'(15), range_t'(50000), 1'b1);
    program_regs(idx_word(20), idx_word(10), idx_word(15), idx_word(25),
                 16'd0, 16'd65535, 16'd2000, 16'd1000);
    send_sample(index_t'(15), range_t'(1500), 1'b1);
  endtask

  task automatic test_random_scans(int unsigned phases, int unsigned items);
    for (int unsigned p = 0; p < phases; p++) begin
      sender_gaps = (p % 3 != 2);
      pick_settings(p);
      run_random_items(items);
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_receiver_holdoff();
    pick_settings(7);
    sender_gaps = 1'b0;
    holdoff_len = 300;
    for (int unsigned k = 0; k < 15; k++)
      send_scan(3, left_lo_idx + index_t'(k), int'(warn_thr), 500, 0);
    drain_results();
    sender_gaps = 1'b1;
    run_random_items(30);
  endtask

  task automatic test_unpaced_tail();
    quiet = 1'b1;
    pick_settings(8);
    run_random_items(130);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_random_scans(6, 95);
    test_receiver_holdoff();
    test_unpaced_tail();
    drain_results();
    $display("tb_top summary: %0d samples in, %0d scan results checked, %0d register settings",
             samples_moved, verdicts_checked, settings_used);
    $display("tb_top summary: windows, ranges, thresholds and output hold-off run");
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
